/* sv/rspe_pkg.sv */
// rspe_pkg: shared GF(256) arithmetic, code table and control types for the parity encoder
`timescale 1ns / 1ps

package rspe_pkg;

   // number of selectable codes and the largest root count any code uses
   localparam int NUM_CODES = 8;
   localparam int MAX_ROOTS = 224;

   // field reduction byte for x^8 + x^4 + x^3 + x^2 + 1
   localparam logic [7:0] GF_REDUCE = 8'h1d;

   // parity count of each code, RS(255,239) up to RS(255,31)
   localparam logic [7:0] NROOTS [NUM_CODES] = '{
      8'd16, 8'd32, 8'd64, 8'd96, 8'd128, 8'd160, 8'd192, 8'd224
   };

   // register indexes on the csr port
   localparam logic CSR_CODE_SELECT = 1'b0;

   // input mode codes
   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_DRAIN  = 1'b1;

   // generator polynomial coefficients, index 0 is the constant term
   typedef logic [MAX_ROOTS:0][7:0] gen_row_type;

   // per-item control for the parity array
   typedef struct packed {
      logic absorb;
      logic first;
      logic drain;
   } rspe_ctl_type;

   // GF(256) multiply, shift-and-add over the eight bits of b
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] prod;
      logic [7:0] x;
      prod = 8'h00;
      x    = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            prod = prod ^ x;
         end
         x = {x[6:0], 1'b0} ^ (x[7] ? GF_REDUCE : 8'h00);
      end
      return prod;
   endfunction

   // generator polynomial with roots alpha^1 .. alpha^n
   function automatic gen_row_type gen_poly(input int n);
      gen_row_type g;
      logic [7:0]  root;
      g    = '0;
      g[0] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < n; i++) begin
         root     = gf_mul(root, 8'h02);
         g[i + 1] = 8'h01;
         for (int j = i; j > 0; j--) begin
            g[j] = g[j - 1] ^ gf_mul(g[j], root);
         end
         g[0] = gf_mul(g[0], root);
      end
      return g;
   endfunction

endpackage

/* sv/rspe_parity_array.sv */
// rspe_parity_array: parity register row with the byte-wide LFSR update and the drain shift row
`timescale 1ns / 1ps

module rspe_parity_array
   import rspe_pkg::*;
#(
   parameter int MAX_PARITY = 224
) (
   input  logic         clock,
   input  logic         reset,
   input  rspe_ctl_type ctl,
   input  logic [2:0]   code,
   input  logic [7:0]   data_byte,
   output logic [7:0]   head_byte
);

   // per-code tap constants for every cell
   logic [7:0] coef_tab [NUM_CODES][MAX_PARITY];
   logic       body_tab [NUM_CODES][MAX_PARITY];
   logic       tail_tab [NUM_CODES][MAX_PARITY];

   for (genvar c = 0; c < NUM_CODES; c++) begin : g_code
      localparam int          N = int'(NROOTS[c]);
      localparam gen_row_type G = gen_poly(N);
      for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
         localparam logic [7:0] COEF = (j < N) ? G[(j < N) ? (N - 1 - j) : 0] : 8'h00;
         assign coef_tab[c][j] = COEF;
         assign body_tab[c][j] = (j < N - 1);
         assign tail_tab[c][j] = (j == N - 1);
      end
   end

   logic [7:0] store_ff  [MAX_PARITY];
   logic [7:0] store_in  [MAX_PARITY];
   logic [7:0] shadow_ff [MAX_PARITY];
   logic [7:0] shadow_in [MAX_PARITY];
   logic [7:0] eff_byte  [MAX_PARITY];
   logic [7:0] up_byte   [MAX_PARITY];
   logic [7:0] feedback;

   // parity as seen by this byte, cleared when it opens a message
   always_comb begin
      for (int j = 0; j < MAX_PARITY; j++) begin
         eff_byte[j] = ctl.first ? 8'h00 : store_ff[j];
      end
      for (int j = 0; j < MAX_PARITY - 1; j++) begin
         up_byte[j] = eff_byte[j + 1];
      end
      up_byte[MAX_PARITY - 1] = 8'h00;
   end

   assign feedback = data_byte ^ eff_byte[0];

   // lfsr step: cells below the root count shift and add their tap, the rest hold
   always_comb begin
      for (int j = 0; j < MAX_PARITY; j++) begin
         if (body_tab[code][j]) begin
            store_in[j] = up_byte[j] ^ gf_mul(feedback, coef_tab[code][j]);
         end else if (tail_tab[code][j]) begin
            store_in[j] = gf_mul(feedback, coef_tab[code][j]);
         end else begin
            store_in[j] = eff_byte[j];
         end
      end
   end

   // drain row: reloaded on absorb, shifts toward the head on each drain
   always_comb begin
      for (int j = 0; j < MAX_PARITY; j++) begin
         shadow_in[j] = shadow_ff[j];
      end
      if (ctl.absorb) begin
         for (int j = 0; j < MAX_PARITY; j++) begin
            shadow_in[j] = store_in[j];
         end
      end else if (ctl.drain) begin
         for (int j = 0; j < MAX_PARITY - 1; j++) begin
            shadow_in[j] = shadow_ff[j + 1];
         end
         shadow_in[MAX_PARITY - 1] = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_PARITY; j++) begin
            store_ff[j]  <= 8'h00;
            shadow_ff[j] <= 8'h00;
         end
      end else begin
         if (ctl.absorb) begin
            for (int j = 0; j < MAX_PARITY; j++) begin
               store_ff[j] <= store_in[j];
            end
         end
         for (int j = 0; j < MAX_PARITY; j++) begin
            shadow_ff[j] <= shadow_in[j];
         end
      end
   end

   assign head_byte = shadow_ff[0];

endmodule

/* sv/reed_solomon_parity_encoder_core.sv */
// reed_solomon_parity_encoder_core: top level of the systematic GF(256) parity encoder
//
// Usage: the req channel carries one item per transfer. An absorb item (mode 0)
// pushes data_byte through the parity LFSR; first set on it clears the parity
// before the byte. A drain item (mode 1) returns the next parity byte on the rsp
// channel, highest order first, with last_parity on the final byte of the code.
// Drains past the end, and all absorbs, give no rsp transfer.
// code_select at csr address 0 picks 16 to 224 parity bytes; write it while idle.
// A drain passes the input register, then the output register. Throughput: one
// item per cycle unless a held result stalls; every parity byte is updated in
// parallel by constant-tap GF multipliers, and the drain reads a shift row, so
// there is no per-item loop. A stalled result holds in the output register while
// one more item waits in the input register; req_stall rises only after that.
// Reset: synchronous; clears parity, drain count, code_select and both valids.
`timescale 1ns / 1ps

module reed_solomon_parity_encoder_core
   import rspe_pkg::*;
#(
   parameter int MAX_PARITY = 224
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_parity_byte,
   output logic        rsp_last_parity,
   // csr port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CNT_W = $clog2(MAX_PARITY + 1);

   // csr register
   logic [2:0] code_sel_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_CODE_SELECT);
   assign prdata    = (paddr[2] == CSR_CODE_SELECT) ? {29'd0, code_sel_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_sel_ff <= 3'd0;
      end else if (csr_write) begin
         code_sel_ff <= pwdata[2:0];
      end
   end

   // largest code at or below the selection whose parity fits the store
   logic [2:0]       code_act;
   logic [CNT_W-1:0] n_cur;

   always_comb begin
      code_act = 3'd0;
      for (int c = 0; c < NUM_CODES; c++) begin
         if ((3'(c) <= code_sel_ff) && (int'(NROOTS[c]) <= MAX_PARITY)) begin
            code_act = 3'(c);
         end
      end
   end

   assign n_cur = NROOTS[code_act][CNT_W-1:0];

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_mode_ff;
   logic [7:0] in_data_ff;
   logic       in_first_ff;
   logic       req_take;
   logic       out_ok;
   logic       fire;
   logic       rsp_valid_ff;

   assign out_ok    = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_ok;
   assign req_stall = in_valid_ff && !out_ok;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff  <= req_mode;
         in_data_ff  <= req_data_byte;
         in_first_ff <= req_first;
      end
   end

   // item execution
   logic [CNT_W-1:0] drain_count_ff;
   logic [CNT_W-1:0] drain_count_in;
   logic             drain_hit;
   rspe_ctl_type     ctl;
   logic [7:0]       head_byte;

   assign drain_hit  = fire && (in_mode_ff == MODE_DRAIN) && (drain_count_ff < n_cur);
   assign ctl.absorb = fire && (in_mode_ff == MODE_ABSORB);
   assign ctl.first  = in_first_ff;
   assign ctl.drain  = drain_hit;

   always_comb begin
      drain_count_in = drain_count_ff;
      if (ctl.absorb) begin
         drain_count_in = '0;
      end else if (drain_hit) begin
         drain_count_in = drain_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_count_ff <= '0;
      end else begin
         drain_count_ff <= drain_count_in;
      end
   end

   rspe_parity_array #(
      .MAX_PARITY (MAX_PARITY)
   ) u_parity_array (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .code      (code_act),
      .data_byte (in_data_ff),
      .head_byte (head_byte)
   );

   // result register
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (drain_hit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (drain_hit) begin
         rsp_byte_ff <= head_byte;
         rsp_last_ff <= (drain_count_ff == n_cur - 1'b1);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_parity_byte = rsp_byte_ff;
   assign rsp_last_parity = rsp_last_ff;

endmodule

/* sv/rspe_checker.sv */
// rspe_checker: port-level checks for the parity encoder, bound to the top level
`timescale 1ns / 1ps

module rspe_checker
   import rspe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_parity_byte,
   input logic        rsp_last_parity,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [2:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);

   // no result is left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the request side stalls only when a result is held by a stalled receiver
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // a held result keeps its byte and end mark
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_parity_byte) && $stable(rsp_last_parity)))
      else $error("stalled result changed");

   // a code_select write reads back on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && (paddr[2] == CSR_CODE_SELECT))
         ##1 (paddr[2] == CSR_CODE_SELECT) |->
         (prdata[2:0] == $past(pwdata[2:0])) && (prdata[31:3] == 29'd0))
      else $error("code_select readback mismatch");

endmodule

bind reed_solomon_parity_encoder_core rspe_checker u_rspe_checker (.*);
